// ===== design/icmp_erc_pkg.sv =====
// Shared constants, codes and helpers for the ICMP echo reply checker.
package icmp_erc_pkg;

    localparam int POS_W = 13;
    localparam int LEN_W = 13;
    localparam int RX_W  = POS_W + 1;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [POS_W-1:0] IP_HEADER_BYTES = 13'd20;
    localparam logic [LEN_W-1:0] MAX_ICMP_BYTES  = 13'd4096;
    localparam logic [LEN_W-1:0] MIN_ICMP_BYTES  = 13'd8;
    localparam logic [POS_W-1:0] POS_MAX         = 13'h1FFF;
    localparam logic [LEN_W-1:0] ICMP_LENGTH_RST = 13'd64;
    localparam logic [15:0]      SUM_VERIFIED    = 16'hFFFF;

    // ICMP message offsets of the captured fields
    localparam logic [POS_W-1:0] OFF_TYPE     = 13'd0;
    localparam logic [POS_W-1:0] OFF_CODE     = 13'd1;
    localparam logic [POS_W-1:0] OFF_IDENT_HI = 13'd4;
    localparam logic [POS_W-1:0] OFF_IDENT_LO = 13'd5;
    localparam logic [POS_W-1:0] OFF_SEQ_HI   = 13'd6;
    localparam logic [POS_W-1:0] OFF_SEQ_LO   = 13'd7;

    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_ID = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ICMP_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        VERDICT_OK       = 3'd0,
        VERDICT_TYPE     = 3'd1,
        VERDICT_CODE     = 3'd2,
        VERDICT_IDENT    = 3'd3,
        VERDICT_SEQ      = 3'd4,
        VERDICT_CHECKSUM = 3'd5,
        VERDICT_SHORT    = 3'd6
    } verdict_t;

    // 16-bit one's complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// ===== design/icmp_echo_reply_checker.sv =====
// ICMP echo reply checker: header skip, field capture, checksum and verdict.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  in       | in_valid/in_stall  | data_byte, last_byte, expected_seq
//  out      | out_valid/out_stall| verdict (one per datagram, on last byte)
//  cfg      | cfg_valid/cfg_ready| cfg_index, cfg_data (expected_id, icmp_length)
//
// One byte per cycle sustained while in_stall is low. A byte is held in the input register;
// its state update and verdict are one pass of logic into the state and result
// registers, so a verdict passes through the input register and then the result register.
// in_stall rises only when a last byte waits on a full, stalled result register.
// rst_n (async, active low) clears datagram state, result valid and sets
// expected_id = 0, icmp_length = 64. cfg_ready is always high.
module icmp_echo_reply_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          data_byte,
    input  logic                                last_byte,
    input  logic [15:0]                         expected_seq,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [2:0]                          verdict,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [icmp_erc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [icmp_erc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    logic [15:0]                    expected_id_reg;
    logic [icmp_erc_pkg::LEN_W-1:0] icmp_length_reg;

    // input register
    logic        in_full_reg, in_full_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic [15:0] in_seq_reg;

    // per-datagram state
    logic [icmp_erc_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  held_reg, held_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  code_reg, code_next;
    logic [15:0] ident_reg, ident_next;
    logic [15:0] seq_reg, seq_next;

    // result register
    logic                   out_valid_reg, out_valid_next;
    icmp_erc_pkg::verdict_t verdict_reg, verdict_next;

    // handshake control
    logic load, consume, emit, out_free;

    // datapath
    logic [icmp_erc_pkg::LEN_W-1:0] len;
    logic [icmp_erc_pkg::LEN_W-1:0] need_len;
    logic [icmp_erc_pkg::POS_W-1:0] off;
    logic                           in_icmp;
    logic [7:0]                     upd_type, upd_code, upd_held;
    logic [15:0]                    upd_ident, upd_seq, upd_sum, final_sum;
    logic [icmp_erc_pkg::RX_W-1:0]  received, icmp_rx, covered, need;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_id_reg <= '0;
            icmp_length_reg <= icmp_erc_pkg::ICMP_LENGTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                icmp_erc_pkg::CFG_EXPECTED_ID: expected_id_reg <= cfg_data[15:0];
                icmp_erc_pkg::CFG_ICMP_LENGTH:
                    icmp_length_reg <= cfg_data[icmp_erc_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // A last byte needs room in the result register; other bytes always pass.
    assign out_free = !out_valid_reg || !out_stall;
    assign consume  = in_full_reg && (!in_last_reg || out_free);
    assign emit     = consume && in_last_reg;
    assign in_stall = in_full_reg && !consume;
    assign load     = in_valid && !in_stall;

    assign in_full_next   = load || (in_full_reg && !consume);
    assign out_valid_next = emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
            in_seq_reg  <= expected_seq;
        end
        if (emit)
        begin
            verdict_reg <= verdict_next;
        end
    end

    // Covered length, clamped to the maximum message size.
    assign len = (icmp_length_reg > icmp_erc_pkg::MAX_ICMP_BYTES)
               ? icmp_erc_pkg::MAX_ICMP_BYTES : icmp_length_reg;
    assign need_len = (len < icmp_erc_pkg::MIN_ICMP_BYTES)
                    ? icmp_erc_pkg::MIN_ICMP_BYTES : len;

    assign in_icmp = (pos_reg >= icmp_erc_pkg::IP_HEADER_BYTES);
    assign off     = pos_reg - icmp_erc_pkg::IP_HEADER_BYTES;

    // Field capture and running sum, including the byte now in the input register.
    always_comb
    begin
        upd_type  = type_reg;
        upd_code  = code_reg;
        upd_ident = ident_reg;
        upd_seq   = seq_reg;
        upd_held  = held_reg;
        upd_sum   = sum_reg;
        if (in_icmp)
        begin
            case (off)
                icmp_erc_pkg::OFF_TYPE:     upd_type = in_byte_reg;
                icmp_erc_pkg::OFF_CODE:     upd_code = in_byte_reg;
                icmp_erc_pkg::OFF_IDENT_HI: upd_ident = {in_byte_reg, ident_reg[7:0]};
                icmp_erc_pkg::OFF_IDENT_LO: upd_ident = {ident_reg[15:8], in_byte_reg};
                icmp_erc_pkg::OFF_SEQ_HI:   upd_seq = {in_byte_reg, seq_reg[7:0]};
                icmp_erc_pkg::OFF_SEQ_LO:   upd_seq = {seq_reg[15:8], in_byte_reg};
                default: ;
            endcase
            if (off < len)
            begin
                if (!off[0])
                    upd_held = in_byte_reg;
                else
                    upd_sum = icmp_erc_pkg::ones_add(sum_reg, {held_reg, in_byte_reg});
            end
        end
    end

    // End-of-datagram bookkeeping: bytes received, covered count, minimum size.
    assign received = {1'b0, pos_reg} + icmp_erc_pkg::RX_W'(1);
    assign icmp_rx  = (received > icmp_erc_pkg::RX_W'(icmp_erc_pkg::IP_HEADER_BYTES))
                    ? received - icmp_erc_pkg::RX_W'(icmp_erc_pkg::IP_HEADER_BYTES)
                    : '0;
    assign covered  = (icmp_rx < {1'b0, len}) ? icmp_rx : {1'b0, len};
    assign need     = icmp_erc_pkg::RX_W'(icmp_erc_pkg::IP_HEADER_BYTES) + {1'b0, need_len};

    // odd covered length: pad the held byte with a zero low byte
    assign final_sum = covered[0] ? icmp_erc_pkg::ones_add(upd_sum, {upd_held, 8'h00})
                                  : upd_sum;

    always_comb
    begin
        if (upd_type != 8'd0)
            verdict_next = icmp_erc_pkg::VERDICT_TYPE;
        else if (upd_code != 8'd0)
            verdict_next = icmp_erc_pkg::VERDICT_CODE;
        else if (upd_ident != expected_id_reg)
            verdict_next = icmp_erc_pkg::VERDICT_IDENT;
        else if (upd_seq != in_seq_reg)
            verdict_next = icmp_erc_pkg::VERDICT_SEQ;
        else if (final_sum != icmp_erc_pkg::SUM_VERIFIED)
            verdict_next = icmp_erc_pkg::VERDICT_CHECKSUM;
        else if (received < need)
            verdict_next = icmp_erc_pkg::VERDICT_SHORT;
        else
            verdict_next = icmp_erc_pkg::VERDICT_OK;
    end

    // State advance; a last byte clears everything for the next datagram.
    always_comb
    begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        held_next  = held_reg;
        type_next  = type_reg;
        code_next  = code_reg;
        ident_next = ident_reg;
        seq_next   = seq_reg;
        if (consume)
        begin
            if (in_last_reg)
            begin
                pos_next   = '0;
                sum_next   = '0;
                held_next  = '0;
                type_next  = '0;
                code_next  = '0;
                ident_next = '0;
                seq_next   = '0;
            end
            else
            begin
                pos_next   = (pos_reg < icmp_erc_pkg::POS_MAX) ? pos_reg + 13'd1 : pos_reg;
                sum_next   = upd_sum;
                held_next  = upd_held;
                type_next  = upd_type;
                code_next  = upd_code;
                ident_next = upd_ident;
                seq_next   = upd_seq;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            held_reg  <= '0;
            type_reg  <= '0;
            code_reg  <= '0;
            ident_reg <= '0;
            seq_reg   <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            held_reg  <= held_next;
            type_reg  <= type_next;
            code_reg  <= code_next;
            ident_reg <= ident_next;
            seq_reg   <= seq_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    // only a last byte blocked by a held result may back-pressure the source
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_full_reg && in_last_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked verdict");

    // datagram state is cleared after each verdict
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (pos_reg == '0 && sum_reg == '0 && ident_reg == '0))
        else $error("datagram state not cleared after last byte");

    // a new result only follows a consumed last byte
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg && out_stall)) |-> $past(emit))
        else $error("result appeared without a last byte");

endmodule
